>>> sv/slmd_pkg.sv
// Shared constants and types of the strict 3x3 local-maximum detector.
package slmd_pkg;

    // Widths of the configuration registers and of the running maxima count.
    localparam int ROWS_REG_W = 11;
    localparam int COLS_REG_W = 9;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CNT_W      = 19;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

    // Input word kinds.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Per-word decision control passed from the front end to the back end.
    typedef struct packed {
        logic decide;     // this word completes the window of a frame element
        logic first;      // decided element is the first of the frame
        logic last;       // decided element is the last of the frame
        logic has_up;     // a row above lies inside the frame
        logic has_down;   // a row below lies inside the frame
        logic has_left;   // a column to the left lies inside the frame
        logic has_right;  // a column to the right lies inside the frame
    } t_dec_ctrl;

endpackage

>>> sv/slmd_front.sv
// Front end: configuration registers, word classification and frame position tracking.
module slmd_front
    import slmd_pkg::*;
#(
    parameter int MAX_COLS    = 256,
    parameter int MAX_ROWS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                 i_cfg_data,
    // classified input word
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_kind,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    // towards the queue
    output logic                                  o_push,
    input  logic                                  i_push_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_value,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_addr,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] o_row,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_col,
    output t_dec_ctrl                             o_ctrl
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int WARM_W = $clog2(MAX_COLS + 2);

    logic [ROWS_REG_W-1:0] r_rows;
    logic [COLS_REG_W-1:0] r_cols;
    logic [ROW_W-1:0]      last_row;
    logic [COL_W-1:0]      last_col;
    logic [WARM_W-1:0]     warm_target;

    logic                  r_started;
    logic                  r_filled;
    logic [COL_W-1:0]      r_addr;
    logic [ROW_W-1:0]      r_wrow;
    logic [WARM_W-1:0]     r_warm;
    logic [ROW_W-1:0]      r_drow;
    logic [COL_W-1:0]      r_dcol;

    logic                  accept;
    logic                  is_drain;
    logic                  cfg_wr;
    logic                  decide;
    logic                  dec_last;
    logic                  addr_wrap;

    // Clamp the frame size to the supported range; a zero counts as one.
    always_comb begin
        if (r_rows == '0) begin
            last_row = '0;
        end else if (32'(r_rows) > 32'(MAX_ROWS)) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(r_rows - 1'b1);
        end
        if (r_cols == '0) begin
            last_col = '0;
        end else if (32'(r_cols) > 32'(MAX_COLS)) begin
            last_col = COL_W'(MAX_COLS - 1);
        end else begin
            last_col = COL_W'(r_cols - 1'b1);
        end
    end

    // A decision is due once cols+1 words of the frame have gone by.
    assign warm_target = WARM_W'(last_col) + WARM_W'(2);

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_ready     = i_push_ready;
    assign accept      = i_valid && i_push_ready;
    assign is_drain    = (i_kind == KIND_DRAIN);

    // A drain word before any word of a frame is swallowed.
    assign o_push   = accept && !(is_drain && !r_started);
    assign o_value  = (is_drain || r_filled) ? '0 : i_sample;
    assign o_addr   = r_addr;
    assign o_row    = r_drow;
    assign o_col    = r_dcol;

    assign decide    = (r_warm == warm_target);
    assign dec_last  = (r_drow == last_row) && (r_dcol == last_col);
    assign addr_wrap = (r_addr == last_col);

    always_comb begin
        o_ctrl.decide    = decide;
        o_ctrl.first     = (r_drow == '0) && (r_dcol == '0);
        o_ctrl.last      = dec_last;
        o_ctrl.has_up    = (r_drow != '0);
        o_ctrl.has_down  = (r_drow != last_row);
        o_ctrl.has_left  = (r_dcol != '0);
        o_ctrl.has_right = (r_dcol != last_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_REG_W'(1);
            r_cols <= COLS_REG_W'(1);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_FRAME_ROWS: r_rows <= i_cfg_data[ROWS_REG_W-1:0];
                REG_FRAME_COLS: r_cols <= i_cfg_data[COLS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr || (o_push && decide && dec_last)) begin
            r_started <= 1'b0;
            r_filled  <= 1'b0;
            r_addr    <= '0;
            r_wrow    <= '0;
            r_warm    <= '0;
            r_drow    <= '0;
            r_dcol    <= '0;
        end else if (o_push) begin
            r_started <= 1'b1;
            r_addr    <= addr_wrap ? '0 : r_addr + 1'b1;
            if (!r_filled && addr_wrap) begin
                if (r_wrow == last_row) begin
                    r_filled <= 1'b1;
                end else begin
                    r_wrow <= r_wrow + 1'b1;
                end
            end
            if (decide) begin
                if (r_dcol == last_col) begin
                    r_dcol <= '0;
                    r_drow <= r_drow + 1'b1;
                end else begin
                    r_dcol <= r_dcol + 1'b1;
                end
            end else begin
                r_warm <= r_warm + 1'b1;
            end
        end
    end

endmodule

>>> sv/slmd_queue.sv
// Short first-in first-out queue between the front and back ends.
module slmd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;

    assign o_push_ready = (r_count != (PTR_W + 1)'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/slmd_back.sv
// Back end: line buffers, 3x3 window, strict-maximum compare and result register.
module slmd_back
    import slmd_pkg::*;
#(
    parameter int MAX_COLS    = 256,
    parameter int MAX_ROWS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // from the queue
    input  logic                                  i_valid,
    output logic                                  o_pop,
    input  logic signed [SAMPLE_BITS-1:0]         i_value,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_addr,
    input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] i_row,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_col,
    input  t_dec_ctrl                             i_ctrl,
    // result fields
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] o_out_row,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_out_col,
    output logic signed [SAMPLE_BITS-1:0]         o_out_value,
    output logic                                  o_is_peak,
    output logic [CNT_W-1:0]                      o_peak_count,
    output logic                                  o_frame_last
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Line buffers: mem_a delays by one row, mem_b by a second row.
    logic signed [SAMPLE_BITS-1:0] mem_a [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] mem_b [MAX_COLS];

    logic                          adv;

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_value;
    logic [COL_W-1:0]              r_s1_addr;
    logic [ROW_W-1:0]              r_s1_row;
    logic [COL_W-1:0]              r_s1_col;
    t_dec_ctrl                     r_s1_ctrl;
    logic signed [SAMPLE_BITS-1:0] r_rd_a;
    logic signed [SAMPLE_BITS-1:0] r_rd_b;

    logic                          r_s2_valid;
    logic [ROW_W-1:0]              r_s2_row;
    logic [COL_W-1:0]              r_s2_col;
    t_dec_ctrl                     r_s2_ctrl;
    logic signed [SAMPLE_BITS-1:0] r_win [3][3];

    logic                          r_out_valid;
    logic [ROW_W-1:0]              r_out_row;
    logic [COL_W-1:0]              r_out_col;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_peak;
    logic                          r_out_last;
    logic [CNT_W-1:0]              r_cnt;

    logic signed [SAMPLE_BITS-1:0] center;
    logic                          peak;
    logic [CNT_W-1:0]              n_cnt;

    // The whole pipeline moves together whenever the result register can take a word.
    assign adv   = !r_out_valid || i_out_ready;
    assign o_pop = i_valid && adv;

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_rd_a          <= mem_a[i_addr];
            mem_a[i_addr]   <= i_value;
            // With one-column frames the second-row entry is still being written.
            if (r_s1_valid && (r_s1_addr == i_addr)) begin
                r_rd_b <= r_rd_a;
            end else begin
                r_rd_b <= mem_b[i_addr];
            end
        end
        if (adv && r_s1_valid) begin
            mem_b[r_s1_addr] <= r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_s1_value <= i_value;
            r_s1_addr  <= i_addr;
            r_s1_row   <= i_row;
            r_s1_col   <= i_col;
            r_s1_ctrl  <= i_ctrl;
        end
        if (adv && r_s1_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_rd_b;
            r_win[1][2] <= r_rd_a;
            r_win[2][2] <= r_s1_value;
            r_s2_row    <= r_s1_row;
            r_s2_col    <= r_s1_col;
            r_s2_ctrl   <= r_s1_ctrl;
        end
    end

    // Strict maximum over the neighbours that lie inside the frame.
    assign center = r_win[1][1];
    always_comb begin
        peak = 1'b1;
        if (r_s2_ctrl.has_up && !(center > r_win[0][1])) peak = 1'b0;
        if (r_s2_ctrl.has_down && !(center > r_win[2][1])) peak = 1'b0;
        if (r_s2_ctrl.has_left && !(center > r_win[1][0])) peak = 1'b0;
        if (r_s2_ctrl.has_right && !(center > r_win[1][2])) peak = 1'b0;
        if (r_s2_ctrl.has_up && r_s2_ctrl.has_left && !(center > r_win[0][0])) peak = 1'b0;
        if (r_s2_ctrl.has_up && r_s2_ctrl.has_right && !(center > r_win[0][2])) peak = 1'b0;
        if (r_s2_ctrl.has_down && r_s2_ctrl.has_left && !(center > r_win[2][0])) peak = 1'b0;
        if (r_s2_ctrl.has_down && r_s2_ctrl.has_right && !(center > r_win[2][2])) peak = 1'b0;
        n_cnt = (r_s2_ctrl.first ? '0 : r_cnt) + CNT_W'(peak);
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid && r_s2_ctrl.decide) begin
            r_out_row   <= r_s2_row;
            r_out_col   <= r_s2_col;
            r_out_value <= center;
            r_out_peak  <= peak;
            r_out_last  <= r_s2_ctrl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (adv) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_ctrl.decide;
            if (r_s2_valid && r_s2_ctrl.decide) begin
                r_cnt <= n_cnt;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_out_value  = r_out_value;
    assign o_is_peak    = r_out_peak;
    assign o_peak_count = r_cnt;
    assign o_frame_last = r_out_last;

endmodule

>>> sv/strict_local_max_3x3_detector.sv
// Strict 3x3 local-maximum detector over a raster-order stream, top level.
// Throughput (dual line buffers): one word in and one result out per clock unless the master stalls.
// The decision for an element is due on the word cols+1 after it; that result word passes
// through the queue, the line-buffer read, the window and the result register to the master side.
// Reset (synchronous, active low) returns the frame size to 1x1 and empties every stage;
// the line buffers need no clearing as out-of-frame taps are masked.
module strict_local_max_3x3_detector
    import slmd_pkg::*;
#(
    parameter int MAX_COLS    = 256,
    parameter int MAX_ROWS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write channel: index 0 is frame_rows, index 1 is frame_cols.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // Slave side, one element per word.
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata, lowest bit up: sample, zero padding
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,
    // tuser: kind (0 pixel, 1 drain)
    input  logic                         i_s_axis_tuser,
    // Master side, one decision per word.
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // tdata, lowest bit up: out_row, out_col, out_value, peak_count, zero padding
    output logic [((((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)
                    + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)
                    + SAMPLE_BITS + CNT_W + 7) / 8) * 8-1:0] o_m_axis_tdata,
    // tuser: is_peak
    output logic                         o_m_axis_tuser,
    // tlast: frame_last
    output logic                         o_m_axis_tlast
);

    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CTRL_W     = $bits(t_dec_ctrl);
    localparam int QW         = CTRL_W + ROW_W + COL_W + COL_W + SAMPLE_BITS;
    localparam int OUT_BITS   = ROW_W + COL_W + SAMPLE_BITS + CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Front end outputs, one entry per word that reaches the pipeline.
    logic                          f_push;
    logic                          q_push_ready;
    logic signed [SAMPLE_BITS-1:0] f_value;
    logic [COL_W-1:0]              f_addr;
    logic [ROW_W-1:0]              f_row;
    logic [COL_W-1:0]              f_col;
    t_dec_ctrl                     f_ctrl;

    // Queue output as seen by the back end.
    logic [QW-1:0]                 q_data;
    logic                          q_valid;
    logic                          b_pop;

    // Result fields from the back end.
    logic [ROW_W-1:0]              b_row;
    logic [COL_W-1:0]              b_col;
    logic signed [SAMPLE_BITS-1:0] b_value;
    logic [CNT_W-1:0]              b_count;

    // The front end classifies each word: a drain word before a frame has started is dropped,
    // an early drain word is written as a zero pixel, and a pixel after the frame is full
    // only moves the window on. It also works out where the pending decision sits.
    slmd_front #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_kind       (i_s_axis_tuser),
        .i_sample     (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_push       (f_push),
        .i_push_ready (q_push_ready),
        .o_value      (f_value),
        .o_addr       (f_addr),
        .o_row        (f_row),
        .o_col        (f_col),
        .o_ctrl       (f_ctrl)
    );

    // The four-entry queue lets the slave side flow on while a result waits on the master side, until full.
    slmd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_push),
        .o_push_ready (q_push_ready),
        .i_data       ({f_ctrl, f_row, f_col, f_addr, f_value}),
        .o_valid      (q_valid),
        .i_pop        (b_pop),
        .o_data       (q_data)
    );

    // The back end holds two rows in line buffers, builds the 3x3 window and
    // registers one result per decision.
    slmd_back #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_pop        (b_pop),
        .i_value      (q_data[SAMPLE_BITS-1:0]),
        .i_addr       (q_data[SAMPLE_BITS +: COL_W]),
        .i_col        (q_data[SAMPLE_BITS + COL_W +: COL_W]),
        .i_row        (q_data[SAMPLE_BITS + 2 * COL_W +: ROW_W]),
        .i_ctrl       (t_dec_ctrl'(q_data[QW-1 -: CTRL_W])),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_row    (b_row),
        .o_out_col    (b_col),
        .o_out_value  (b_value),
        .o_is_peak    (o_m_axis_tuser),
        .o_peak_count (b_count),
        .o_frame_last (o_m_axis_tlast)
    );

    // Result fields packed from the lowest bit up, zero-filled to whole bytes.
    assign o_m_axis_tdata = OUT_DATA_W'({b_count, b_value, b_col, b_row});

endmodule

>>> tb/tb_strict_local_max_3x3_detector.sv
// Self-checking testbench for the strict 3x3 local-maximum detector.
module tb_strict_local_max_3x3_detector
    import slmd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The block is used with its default sizes; these mirror them for the predictor.
    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 1024;
    localparam int SAMPLE_W    = 16;
    localparam int ROW_W       = 10;
    localparam int COL_W       = 8;
    localparam int IN_W        = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_W       = ((ROW_W + COL_W + SAMPLE_W + CNT_W + 7) / 8) * 8;
    localparam int VAL_LSB     = ROW_W + COL_W;
    localparam int CNT_LSB     = VAL_LSB + SAMPLE_W;
    localparam int RING_DEPTH  = 2 * MAX_COLS + 4;
    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_GAP  = 8;

    typedef enum logic [1:0] {
        VALUES_FULL,
        VALUES_NARROW,
        VALUES_EXTREME
    } t_value_mode;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
    } t_stream_word;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [SAMPLE_W-1:0] value;
        logic                is_peak;
        logic [CNT_W-1:0]    peak_count;
        logic                frame_last;
    } t_decision;

    // Every input of the block holds a known value from time zero.
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]       i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = 1'b0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_W-1:0]      o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    strict_local_max_3x3_detector uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Words waiting to be offered and decisions waiting to come out.
    t_stream_word pending_words[$];
    t_decision    decisions_due[$];
    int unsigned  error_count = 0;

    // Idling controls, changed by the stimulus between phases.
    logic sender_bursty = 1'b0;
    logic rx_stalls     = 1'b0;

    // Predictor state: raw register contents, the sample history of the frame and
    // the two frame counters.
    int unsigned        frame_rows_q = 1;
    int unsigned        frame_cols_q = 1;
    logic signed [15:0] sample_ring[RING_DEPTH] = '{default: '0};
    int unsigned        words_in_frame = 0;
    int unsigned        peaks_in_frame = 0;

    // A register value of zero counts as one, anything beyond the maximum as the maximum.
    function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned top);
        if (raw == 0) begin
            return 1;
        end
        return (raw > top) ? top : raw;
    endfunction

    // Works out what one accepted word causes and records the decision, if any.
    function automatic void predict_decision(input logic kind, input logic [SAMPLE_W-1:0] raw);
        int unsigned        rows, cols, total, n, p, r, c;
        int                 dr, dc, q;
        logic signed [15:0] centre;
        logic               peak;
        t_decision          d;
        rows  = clamp_dim(frame_rows_q, MAX_ROWS);
        cols  = clamp_dim(frame_cols_q, MAX_COLS);
        total = rows * cols;
        n     = words_in_frame;
        // A drain word with no frame under way is simply dropped.
        if (kind == KIND_DRAIN && n == 0) begin
            return;
        end
        // An early drain stands for a zero pixel; a late pixel only flushes.
        if (n < total) begin
            sample_ring[n % RING_DEPTH] = (kind == KIND_DRAIN) ? 16'sd0 : $signed(raw);
        end
        words_in_frame = n + 1;
        if (n < cols + 1) begin
            return;
        end
        p = n - (cols + 1);
        if (p >= total) begin
            words_in_frame = 0;
            peaks_in_frame = 0;
            return;
        end
        r      = p / cols;
        c      = p % cols;
        centre = sample_ring[p % RING_DEPTH];
        peak   = 1'b1;
        // Only neighbours inside the frame take part, and a tie is not a maximum.
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && !(dr < 0 && r == 0) && !(dr > 0 && r + 1 >= rows)
                        && !(dc < 0 && c == 0) && !(dc > 0 && c + 1 >= cols)) begin
                    q = int'(p) + dr * int'(cols) + dc;
                    if (centre <= sample_ring[q % RING_DEPTH]) begin
                        peak = 1'b0;
                    end
                end
            end
        end
        if (peak) begin
            peaks_in_frame = (peaks_in_frame + 1) & ((1 << CNT_W) - 1);
        end
        d.row        = ROW_W'(r);
        d.col        = COL_W'(c);
        d.value      = centre;
        d.is_peak    = peak;
        d.peak_count = CNT_W'(peaks_in_frame);
        d.frame_last = (p + 1 == total);
        decisions_due.push_back(d);
        if (p + 1 == total) begin
            words_in_frame = 0;
            peaks_in_frame = 0;
        end
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Sender: offers queued words in bursts with gaps between them, or back to back.
    // tvalid is assigned at most once per edge so that a word that follows an
    // accepted one keeps tvalid high throughout.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin : word_sender
        logic         accepted;
        logic         next_valid;
        t_stream_word w;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            accepted = i_s_axis_tvalid && o_s_axis_tready;
            if (accepted) begin
                predict_decision(i_s_axis_tuser, i_s_axis_tdata[SAMPLE_W-1:0]);
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (sender_bursty && burst_left == 0) begin
                    gap_left = $urandom_range(1, 8);
                end
            end
            // A word on offer that was not taken stays exactly as it is.
            if (!(i_s_axis_tvalid && !accepted)) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                    end
                    w = pending_words.pop_front();
                    i_s_axis_tdata <= IN_W'(w.sample);
                    i_s_axis_tuser <= w.kind;
                    next_valid = 1'b1;
                end
                i_s_axis_tvalid <= next_valid;
            end
        end
    end

    // Receiver: checks every result word against the oldest decision due and stalls on
    // a rotating pattern that is reloaded now and then. It also watches for a hang.
    logic [15:0] stall_pattern = 16'h0000;
    int unsigned pattern_age   = 0;
    int unsigned quiet_cycles  = 0;

    always @(posedge i_clk) begin : result_checker
        t_decision d;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            quiet_cycles = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (decisions_due.size() == 0) begin
                    $display("%0t: result word with nothing due: row %0d col %0d value %0d",
                             $time, o_m_axis_tdata[ROW_W-1:0], o_m_axis_tdata[VAL_LSB-1:ROW_W],
                             $signed(o_m_axis_tdata[CNT_LSB-1:VAL_LSB]));
                    error_count++;
                end else begin
                    d = decisions_due.pop_front();
                    check_field("row", d.row, o_m_axis_tdata[ROW_W-1:0]);
                    check_field("col", d.col, o_m_axis_tdata[VAL_LSB-1:ROW_W]);
                    check_field("value", $signed(d.value),
                                $signed(o_m_axis_tdata[CNT_LSB-1:VAL_LSB]));
                    check_field("peak_count", d.peak_count,
                                o_m_axis_tdata[CNT_LSB+CNT_W-1:CNT_LSB]);
                    check_field("is_peak", d.is_peak, o_m_axis_tuser);
                    check_field("frame_last", d.frame_last, o_m_axis_tlast);
                end
            end

            // Any handshake on any channel counts as progress.
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end else begin
                // The pattern always keeps at least one ready slot, so stalls stay short.
                pattern_age++;
                if (pattern_age >= 48) begin
                    pattern_age   = 0;
                    stall_pattern = 16'($urandom) & ~(16'h0001 << $urandom_range(15));
                end else begin
                    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                end
                i_m_axis_tready <= !rx_stalls || !stall_pattern[0];
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_value_mode mode);
        logic [SAMPLE_W-1:0] v;
        case (mode)
            VALUES_NARROW: begin
                // A narrow spread makes ties and genuine maxima both common.
                v = 16'($urandom_range(6)) - 16'd3;
            end
            VALUES_EXTREME: begin
                case ($urandom_range(4))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    3: v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            default: begin
                v = 16'($urandom);
            end
        endcase
        return v;
    endfunction

    task automatic queue_word(input logic kind, input logic [SAMPLE_W-1:0] sample);
        t_stream_word w;
        w.kind   = kind;
        w.sample = sample;
        pending_words.push_back(w);
    endtask

    // Waits until every word has been taken and every decision has come out.
    task automatic wait_results_done;
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || i_s_axis_tvalid || decisions_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        // A write abandons whatever frame was under way.
        if (index == REG_FRAME_ROWS) begin
            frame_rows_q = value & 11'h7FF;
        end else begin
            frame_cols_q = value & 11'h1FF;
        end
        words_in_frame = 0;
        peaks_in_frame = 0;
    endtask

    // Lets the block settle, picks new idling behaviour and writes the frame size.
    // Bit 0 of which selects the row register, bit 1 the column register. The two
    // upper data bits of a column write are ignored by the block and carry noise.
    task automatic set_frame(input int unsigned rows_raw, input int unsigned cols_raw,
                             input logic [1:0] which);
        logic [CFG_DATA_W-1:0] cols_data;
        wait_results_done();
        repeat (SETTLE_GAP) @(posedge i_clk);
        sender_bursty <= ($urandom_range(9) < 6);
        rx_stalls     <= ($urandom_range(9) < 6);
        cols_data = {2'($urandom), 9'(cols_raw)};
        if (which == 2'b11 && $urandom_range(1) == 1) begin
            write_reg(REG_FRAME_COLS, cols_data);
            write_reg(REG_FRAME_ROWS, 11'(rows_raw));
        end else begin
            if (which[0]) begin
                write_reg(REG_FRAME_ROWS, 11'(rows_raw));
            end
            if (which[1]) begin
                write_reg(REG_FRAME_COLS, cols_data);
            end
        end
    endtask

    // Queues one frame of the current size and its drain tail, or only its first
    // stop words. With noise the frame may start with a stray drain, carry early
    // drains among its pixels and stray pixels in its tail. A non-zero pause_at
    // holds the frame back at that word until every decision so far has come out.
    task automatic queue_frame(input t_value_mode mode, input logic noisy,
                               input int unsigned stop, input int unsigned pause_at,
                               output int unsigned queued);
        int unsigned rows, cols, total, i;
        rows  = clamp_dim(frame_rows_q, MAX_ROWS);
        cols  = clamp_dim(frame_cols_q, MAX_COLS);
        total = rows * cols;
        queued = 0;
        @(negedge i_clk);
        if (noisy && $urandom_range(2) == 0) begin
            queue_word(KIND_DRAIN, 16'($urandom));
        end
        for (i = 0; i < total + cols + 1 && i < stop; i++) begin
            if (pause_at != 0 && i == pause_at) begin
                wait_results_done();
            end
            if (i < total) begin
                queue_word((noisy && $urandom_range(15) == 0) ? KIND_DRAIN : KIND_PIXEL,
                           pick_sample(mode));
            end else begin
                queue_word((noisy && $urandom_range(7) == 0) ? KIND_PIXEL : KIND_DRAIN,
                           16'($urandom));
            end
            queued++;
        end
    endtask

    initial begin : stimulus
        int unsigned random_words, queued, rows_raw, cols_raw, frames, f, total, stop;
        logic [1:0]  which;
        t_value_mode mode;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size of one element: a stray drain, the largest value, a pixel past the
        // end that only flushes, then the drain that brings the decision out.
        @(negedge i_clk);
        queue_word(KIND_DRAIN, 16'h1234);
        queue_word(KIND_PIXEL, 16'h7FFF);
        queue_word(KIND_PIXEL, 16'hFFFB);
        queue_word(KIND_DRAIN, 16'h0000);

        // Three by three with both extremes, ties between neighbours and a stray
        // pixel among the drain words.
        set_frame(3, 3, 2'b11);
        @(negedge i_clk);
        queue_word(KIND_PIXEL, 16'h8000);
        queue_word(KIND_PIXEL, 16'h0005);
        queue_word(KIND_PIXEL, 16'h0005);
        queue_word(KIND_PIXEL, 16'h0000);
        queue_word(KIND_PIXEL, 16'h7FFF);
        queue_word(KIND_PIXEL, 16'hFFFF);
        queue_word(KIND_PIXEL, 16'h0007);
        queue_word(KIND_PIXEL, 16'h0007);
        queue_word(KIND_PIXEL, 16'h8000);
        queue_word(KIND_DRAIN, 16'h0000);
        queue_word(KIND_PIXEL, 16'hAAAA);
        queue_word(KIND_DRAIN, 16'hFFFF);
        queue_word(KIND_DRAIN, 16'h0000);

        // Two rows only, with an early drain that stands for a zero among negatives.
        set_frame(2, 3, 2'b01);
        @(negedge i_clk);
        queue_word(KIND_PIXEL, 16'hFFFF);
        queue_word(KIND_DRAIN, 16'h5555);
        queue_word(KIND_PIXEL, 16'hFFFD);
        queue_word(KIND_PIXEL, 16'hFFFC);
        queue_word(KIND_PIXEL, 16'hFFFB);
        queue_word(KIND_PIXEL, 16'hFFFF);
        repeat (4) queue_word(KIND_DRAIN, 16'h0000);

        // The tallest frame, asked for with an over-range row count. Half way down
        // the sender holds back until everything so far has come out.
        set_frame(2047, 1, 2'b11);
        queue_frame(VALUES_NARROW, 1'b0, '1, 500, queued);

        // An over-range width on a tall frame, abandoned after its first rows.
        set_frame(1024, 511, 2'b11);
        queue_frame(VALUES_EXTREME, 1'b1, 520, 0, queued);

        // Zero in both registers means a single element.
        set_frame(0, 0, 2'b11);
        repeat (3) queue_frame(VALUES_NARROW, 1'b1, '1, 0, queued);

        // Random small frames, a few of them cut short, until enough words have gone in.
        random_words = 0;
        while (random_words < 200) begin
            case ($urandom_range(9))
                0: rows_raw = 0;
                1: rows_raw = $urandom_range(7, 12);
                default: rows_raw = $urandom_range(1, 6);
            endcase
            case ($urandom_range(9))
                0: cols_raw = 0;
                1: cols_raw = $urandom_range(11, 20);
                default: cols_raw = $urandom_range(1, 10);
            endcase
            // The first random phase must replace the wide size left behind above.
            which = (random_words == 0) ? 2'b11 : 2'($urandom_range(1, 3));
            set_frame(rows_raw, cols_raw, which);
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                mode  = t_value_mode'($urandom_range(2));
                total = clamp_dim(frame_rows_q, MAX_ROWS) * clamp_dim(frame_cols_q, MAX_COLS)
                        + clamp_dim(frame_cols_q, MAX_COLS) + 1;
                stop  = (f + 1 == frames && $urandom_range(4) == 0)
                        ? $urandom_range(1, total - 1) : total;
                queue_frame(mode, $urandom_range(1), stop, 0, queued);
                random_words += queued;
            end
        end

        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/slmd_pkg.sv
sv/slmd_front.sv
sv/slmd_queue.sv
sv/slmd_back.sv
sv/strict_local_max_3x3_detector.sv
tb/tb_strict_local_max_3x3_detector.sv
